>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on the rising clock edge and
// disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");

// Check that cons holds whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons))

`endif

>>> src/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg
// Types and fixed constants of the YUYV to RGB888 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package y2r_pkg;

    localparam int BYTE_W    = 8;
    localparam int SUM_W     = 27;   // signed Q10.16, holds every channel sum
    localparam int FRAC_BITS = 16;
    localparam int WHOLE_W   = SUM_W - 1 - FRAC_BITS;
    localparam int IN_DATA_W  = 4 * BYTE_W;
    localparam int OUT_DATA_W = 6 * BYTE_W;

    typedef logic        [BYTE_W-1:0] t_chan;
    typedef logic signed [SUM_W-1:0]  t_sum;

    // Unsigned Q2.16 coefficients
    localparam t_sum K_RED_V   = 27'sd89831;
    localparam t_sum K_GREEN_V = 27'sd45744;
    localparam t_sum K_GREEN_U = 27'sd22127;
    localparam t_sum K_BLUE_U  = 27'sd113538;

    localparam logic [BYTE_W:0] CHROMA_OFFSET = 9'd128;
    localparam logic [WHOLE_W-1:0] CHANNEL_MAX = WHOLE_W'(255);
    localparam logic [15:0] SCALE_MUL   = 16'd220;
    localparam int          SCALE_SHIFT = 8;
    localparam t_chan       OUT_MAX     = 8'd219;

endpackage

`default_nettype wire

>>> src/yuyv_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter_top
// Three-stage pipelined YUYV 4:2:2 to RGB888 converter with 220/256 scaling.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one word per YUYV group, tdata = {V, Y1, U, Y0} (Y0 in the
//   low byte), tlast marks the last group of a frame.
//   Master stream: one word per group carrying two RGB pixels, tdata =
//   {B1, G1, R1, B0, G0, R0} (R0 in the low byte); tlast is the input tlast.
//   Path: an accepted group loads stage 1, then stage 2, then stage 3,
//   whose valid bit drives o_m_tvalid; the word leaves when tready is high.
//   Throughput: one group per clock while tready is high; the pipeline is
//   three register stages (chroma multiply, channel sums, clamp and scale).
//   Reset (synchronous, active low) empties the pipeline; no data survives.
//   Stall: when the receiver drops tready the last stage holds its word and
//   earlier stages keep filling bubbles; tready to the source falls only when
//   all three stages hold valid words.
// ----------------------------------------------------------------------------
`default_nettype none

module yuyv_to_rgb_converter_top
    import y2r_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    // fields from bit 0: first_luma[7:0], chroma_blue[7:0],
    //                    second_luma[7:0], chroma_red[7:0]
    input  wire  [IN_DATA_W-1:0]  i_s_tdata,
    input  wire                   i_s_tlast,   // frame_end
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    // fields from bit 0: red_first, green_first, blue_first,
    //                    red_second, green_second, blue_second (8 bits each)
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast    // frame_end_out
);

    // Clamp a Q10.16 sum to 0..255 (truncating) and scale by 220/256.
    function automatic t_chan clamp_scale(input t_sum s);
        logic [WHOLE_W-1:0] whole;
        t_chan              c;
        logic [15:0]        prod;
        whole = s[SUM_W-2:FRAC_BITS];
        if (s[SUM_W-1]) begin
            c = '0;
        end else if (whole > CHANNEL_MAX) begin
            c = CHANNEL_MAX[BYTE_W-1:0];
        end else begin
            c = whole[BYTE_W-1:0];
        end
        prod = {8'h00, c} * SCALE_MUL;
        return t_chan'(prod >> SCALE_SHIFT);
    endfunction

    // Stage valid bits
    logic r_v1;
    logic r_v2;

    // Stage enables: a stage loads when it is empty or its word moves on.
    logic en1, en2, en3;
    assign en3 = !o_m_tvalid || i_m_tready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_s_tready = en1;

    // ---------------- Stage 1: chroma offsets and products ----------------
    t_chan               r_y0, r_y1;
    logic                r_last1;
    t_sum                r_p_rv, r_p_gv, r_p_gu, r_p_bu;
    logic signed [BYTE_W:0] n_du, n_dv;

    assign n_du = $signed({1'b0, i_s_tdata[15:8]})  - $signed(CHROMA_OFFSET);
    assign n_dv = $signed({1'b0, i_s_tdata[31:24]}) - $signed(CHROMA_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_y0    <= i_s_tdata[7:0];
            r_y1    <= i_s_tdata[23:16];
            r_last1 <= i_s_tlast;
            r_p_rv  <= K_RED_V   * t_sum'(n_dv);
            r_p_gv  <= K_GREEN_V * t_sum'(n_dv);
            r_p_gu  <= K_GREEN_U * t_sum'(n_du);
            r_p_bu  <= K_BLUE_U  * t_sum'(n_du);
        end
    end

    // ---------------- Stage 2: channel sums for both pixels ----------------
    logic r_last2;
    t_sum r_s [6];
    t_sum n_base0, n_base1;

    assign n_base0 = $signed({3'b000, r_y0, 16'h0000});
    assign n_base1 = $signed({3'b000, r_y1, 16'h0000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_last2 <= r_last1;
            r_s[0]  <= n_base0 + r_p_rv;
            r_s[1]  <= n_base0 - r_p_gv - r_p_gu;
            r_s[2]  <= n_base0 + r_p_bu;
            r_s[3]  <= n_base1 + r_p_rv;
            r_s[4]  <= n_base1 - r_p_gv - r_p_gu;
            r_s[5]  <= n_base1 + r_p_bu;
        end
    end

    // ---------------- Stage 3: clamp, scale, output register ----------------
    logic r_v3;
    logic r_last3;
    logic [OUT_DATA_W-1:0] r_data3;
    logic [OUT_DATA_W-1:0] n_data3;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_data3[k*BYTE_W +: BYTE_W] = clamp_scale(r_s[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_last3 <= r_last2;
            r_data3 <= n_data3;
        end
    end

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = r_data3;
    assign o_m_tlast  = r_last3;

endmodule

`default_nettype wire

>>> src/y2r_checker.sv
// ----------------------------------------------------------------------------
// y2r_checker
// Port-level checks of the YUYV to RGB888 converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module y2r_checker
    import y2r_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_s_tvalid,
    input wire                   o_s_tready,
    input wire [IN_DATA_W-1:0]   i_s_tdata,
    input wire                   i_s_tlast,
    input wire                   o_m_tvalid,
    input wire                   i_m_tready,
    input wire [OUT_DATA_W-1:0]  o_m_tdata,
    input wire                   o_m_tlast
);

    logic s_acc;
    logic all_in_range;
    assign s_acc = i_s_tvalid && o_s_tready;

    always_comb begin
        all_in_range = 1'b1;
        for (int k = 0; k < 6; k++) begin
            if (o_m_tdata[k*BYTE_W +: BYTE_W] > OUT_MAX) begin
                all_in_range = 1'b0;
            end
        end
    end

    // Hold a stalled output word.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))

    // Every scaled channel stays within 0..219.
    `ASSERT_IMPLIES(a_chan_range, i_clk, i_rst_n, o_m_tvalid, all_in_range)

    // Without a stall an accepted group passes the stages and reaches the output.
    `ASSERT_CLK(a_latency, i_clk, i_rst_n,
        (s_acc ##1 i_m_tready ##1 i_m_tready) |=> o_m_tvalid)

    // The frame marker travels with its group.
    `ASSERT_CLK(a_last_follows, i_clk, i_rst_n,
        (s_acc ##1 i_m_tready ##1 i_m_tready) |=> (o_m_tlast == $past(i_s_tlast, 3)))

endmodule

bind yuyv_to_rgb_converter_top y2r_checker u_y2r_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

>>> tb/yuyv_to_rgb_converter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter_top_test
// Self-checking bench for the YUYV to RGB converter: streams YUYV groups in,
// predicts both RGB pixels of every accepted group in fixed point, and
// compares each output word in order, under random idling on both sides.
// ----------------------------------------------------------------------------

module yuyv_to_rgb_converter_top_test;
    import y2r_pkg::*;

    // One YUYV group as it enters the converter
    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] u;
        logic [7:0] y1;
        logic [7:0] v;
        logic       last;
    } t_yuyv_group;

    // The two RGB pixels predicted for one group
    typedef struct packed {
        t_chan r0;
        t_chan g0;
        t_chan b0;
        t_chan r1;
        t_chan g1;
        t_chan b1;
        logic  last;
    } t_rgb_pair;

    // Coefficients in unsigned Q2.16, rounded to nearest
    localparam int RV_Q16   = 89831;
    localparam int GV_Q16   = 45744;
    localparam int GU_Q16   = 22127;
    localparam int BU_Q16   = 113538;
    localparam int Q_SHIFT  = 16;
    localparam int MID_CODE = 128;

    localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int HOLD_AT     = 1400;  // groups accepted before the long back-pressure
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 12;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;  // y0, u, y1, v from bit 0
    logic                  i_s_tlast  = 1'b0; // frame_end
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;        // r0, g0, b0, r1, g1, b1 from bit 0
    logic                  o_m_tlast;         // frame_end_out

    t_yuyv_group group_q[$];        // groups waiting to be offered
    t_rgb_pair   expected_rgb_q[$]; // predictions for accepted groups, oldest first
    t_yuyv_group cur_group;         // group currently on the slave side

    int send_idle_pct = 27;
    int recv_idle_pct = 73;
    int groups_accepted = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    yuyv_to_rgb_converter_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Truncate a Q.16 sum toward zero, clamp to 0..255, scale by 220/256.
    function automatic t_chan finish_channel(int sum);
        int whole;
        if (sum < 0) begin
            return '0;
        end
        whole = sum >>> Q_SHIFT;
        if (whole > 255) begin
            whole = 255;
        end
        return t_chan'((whole * 220) >>> 8);
    endfunction

    function automatic t_rgb_pair convert_group(t_yuyv_group grp);
        t_rgb_pair px;
        int du;
        int dv;
        int base0;
        int base1;
        du    = int'(grp.u) - MID_CODE;
        dv    = int'(grp.v) - MID_CODE;
        base0 = int'(grp.y0) << Q_SHIFT;
        base1 = int'(grp.y1) << Q_SHIFT;
        px.r0 = finish_channel(base0 + RV_Q16 * dv);
        px.g0 = finish_channel(base0 - GV_Q16 * dv - GU_Q16 * du);
        px.b0 = finish_channel(base0 + BU_Q16 * du);
        px.r1 = finish_channel(base1 + RV_Q16 * dv);
        px.g1 = finish_channel(base1 - GV_Q16 * dv - GU_Q16 * du);
        px.b1 = finish_channel(base1 + BU_Q16 * du);
        px.last = grp.last;
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_group(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
                              logic [7:0] v, logic last);
        t_yuyv_group grp;
        grp.y0 = y0;
        grp.u = u;
        grp.y1 = y1;
        grp.v = v;
        grp.last = last;
        group_q.insert(group_q.size(), grp);
    endtask

    // Mostly uniform bytes, with a bias toward the clamp and offset corners
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[7];
        corners = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        if ($urandom_range(5) == 0) begin
            return corners[$urandom_range(6)];
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic push_random_groups(int count);
        repeat (count) begin
            push_group(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                       $urandom_range(15) == 0);
        end
    endtask

    // Hold until every queued group has been taken by the converter
    task automatic wait_groups_sent();
        while (group_q.size() != 0 || i_s_tvalid) begin
            @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Slave-side driver: offer queued groups, log a prediction on every accept
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin : drive_groups
        t_yuyv_group nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_rgb_q.insert(expected_rgb_q.size(), convert_group(cur_group));
                groups_accepted <= groups_accepted + 1;
            end
            // Advance only when the offered word is gone or none is offered
            if (!i_s_tvalid || o_s_tready) begin
                if (group_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = group_q.pop_front();
                    cur_group  <= nxt;
                    i_s_tdata  <= {nxt.v, nxt.y1, nxt.u, nxt.y0};
                    i_s_tlast  <= nxt.last;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Master-side ready: random stalls, plus one long hold-off that lets the
    // pipeline fill and push back on the source
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (!hold_done && groups_accepted >= HOLD_AT) begin
            hold_left  <= HOLD_CYCLES;
            hold_done  <= 1'b1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each output word with the oldest prediction
    // ------------------------------------------------------------------------

    task automatic check_field(string name, t_chan want, t_chan got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_pixels
        t_rgb_pair want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_rgb_q.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual %h / last %b",
                         $time, o_m_tdata, o_m_tlast);
                mismatches++;
            end else begin
                want = expected_rgb_q.pop_front();
                check_field("red_first",     want.r0, o_m_tdata[7:0]);
                check_field("green_first",   want.g0, o_m_tdata[15:8]);
                check_field("blue_first",    want.b0, o_m_tdata[23:16]);
                check_field("red_second",    want.r1, o_m_tdata[31:24]);
                check_field("green_second",  want.g1, o_m_tdata[39:32]);
                check_field("blue_second",   want.b1, o_m_tdata[47:40]);
                check_field("frame_end_out", t_chan'(want.last), t_chan'(o_m_tlast));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: drop out when no word moves on either side for too long
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: directed corners, then three random phases
    // ------------------------------------------------------------------------

    initial begin
        // Directed: range extremes, neutral chroma, clamp on both ends
        push_group(8'd0,   8'd0,   8'd0,   8'd0,   1'b0); // negative sums on R and B
        push_group(8'd255, 8'd255, 8'd255, 8'd255, 1'b1); // saturate R and B
        push_group(8'd0,   8'd128, 8'd255, 8'd128, 1'b0); // gray black and white
        push_group(8'd128, 8'd128, 8'd127, 8'd128, 1'b0);
        push_group(8'd0,   8'd255, 8'd255, 8'd0,   1'b0); // R below zero, B saturates
        push_group(8'd255, 8'd0,   8'd0,   8'd255, 1'b1);
        push_group(8'd255, 8'd0,   8'd255, 8'd0,   1'b0); // green saturates
        push_group(8'd16,  8'd128, 8'd235, 8'd128, 1'b0);
        push_group(8'd1,   8'd127, 8'd254, 8'd129, 1'b0); // one step off neutral
        push_group(8'd254, 8'd129, 8'd1,   8'd127, 1'b0);
        push_group(8'hAA,  8'h55,  8'h55,  8'hAA,  1'b1); // alternating bits
        push_group(8'h55,  8'hAA,  8'hAA,  8'h55,  1'b0);
        push_group(8'd100, 8'd0,   8'd200, 8'd128, 1'b0); // blue only below zero
        push_group(8'd100, 8'd255, 8'd200, 8'd128, 1'b0); // blue only saturating
        push_group(8'd100, 8'd128, 8'd200, 8'd0,   1'b0); // R below zero, G saturates
        push_group(8'd100, 8'd128, 8'd200, 8'd255, 1'b1); // red only saturating
        push_group(8'd200, 8'd140, 8'd60,  8'd110, 1'b0);
        push_group(8'd80,  8'd90,  8'd170, 8'd180, 1'b1);

        // Sender mostly busy, receiver mostly stalled
        push_random_groups(600);
        wait_groups_sent();

        // Sender mostly idle, receiver mostly ready
        send_idle_pct = 73;
        recv_idle_pct = 27;
        push_random_groups(600);
        wait_groups_sent();

        // Full rate both ways; the long hold-off lands in this phase
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random_groups(632);
        wait_groups_sent();

        while (expected_rgb_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && expected_rgb_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
